// ===== rtl/core/lcg_ranged_random_no_repeat_macros.svh =====
// Assertion helpers for the ranged random generator.
// Both expect clk and rst_n in scope.
`ifndef LCG_RANGED_RANDOM_NO_REPEAT_MACROS_SVH
`define LCG_RANGED_RANDOM_NO_REPEAT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LRR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LRR_ASSERT_IMP(lbl, ante, cons, msg)
`define LRR_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/lrr_pkg.sv =====
`default_nettype none

package lrr_pkg;

  localparam int unsigned SEED_W  = 64;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned MUL_W   = 30;
  localparam int unsigned PROD_W  = VAL_W + MUL_W;
  localparam int unsigned SHIFT   = 16;
  localparam int unsigned DIV_BITS = SEED_W - SHIFT;
  localparam int unsigned CNT_W   = $clog2(DIV_BITS);

  localparam logic [MUL_W-1:0]  LCG_MUL    = 30'd725472321;
  localparam logic [SEED_W-1:0] LCG_INC    = 64'd1;
  localparam logic [SEED_W-1:0] SEED_RESET = 64'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADV,
    ST_DIV,
    ST_DECIDE,
    ST_FINISH
  } lrr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request, order bounds, optional reseed
    logic mul_lo;      // low seed word times multiplier
    logic mul_hi;      // high seed word times multiplier
    logic adv;         // commit new seed, arm divider
    logic div_step;    // one restoring division bit
    logic set_redraw;  // mark second draw
    logic take;        // load output register and last result
  } lrr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bounds_eq;
    logic repeat_hit;
    logic redraw_done;
  } lrr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lcg_ranged_random_no_repeat.sv =====
// Channel | Dir | Payload
// --------+-----+-------------------------------------------------------------
// in_     | in  | tdata: low_bound, high_bound, new_seed; tuser: allow_repeat, reseed
// out_    | out | tdata: value; tuser: redrawn
// cfg_    | in  | wr_data: live seed (reset still loads seed 1)
//
// One request at a time. A draw is a seed update (two 32x30 partial
// products in MUL_LO and MUL_HI, a 64-bit add in ADV), a bit-serial modulo
// of the 48 upper seed bits and a decision in DECIDE; a repeat runs one
// second draw, and equal bounds go from ADV straight to FINISH.
// Reset is synchronous, active low; seed returns to 1, last result to 0.
// The output register holds a finished beat, so a new request can be
// taken while out_tready is low; a second result waits in FINISH.
`default_nettype none
`include "lcg_ranged_random_no_repeat_macros.svh"

module lcg_ranged_random_no_repeat (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // config
  input  wire logic         cfg_wr_en,
  input  wire logic [63:0]  cfg_wr_data,
  // request
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // [31:0] low_bound, [63:32] high_bound,
                                        // [127:64] new_seed
  input  wire logic [1:0]   in_tuser,   // [0] allow_repeat, [1] reseed
  // result
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // [31:0] value
  output logic              out_tuser   // [0] redrawn
);
  import lrr_pkg::*;

  lrr_cmd_t           cmd;
  lrr_sts_t           sts;
  logic signed [31:0] value;
  logic               redrawn;

  lrr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lrr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .low_bound    (signed'(in_tdata[31:0])),
    .high_bound   (signed'(in_tdata[63:32])),
    .allow_repeat (in_tuser[0]),
    .reseed       (in_tuser[1]),
    .new_seed     (in_tdata[127:64]),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .redrawn      (redrawn)
  );

  assign out_tdata = value;
  assign out_tuser = redrawn;

  // a taken request blocks the input until its draw is done
  `LRR_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "input ready right after accept")
  // never overwrite a result still waiting on the output
  `LRR_ASSERT_IMP(a_take_slot_free, cmd.take, !out_tvalid || out_tready,
    "output register overwritten")
  // no division for equal bounds (width would be zero)
  `LRR_ASSERT_IMP(a_div_width_nz, cmd.div_step, !sts.bounds_eq,
    "modulo by zero width")
  // second draw happens at most once per request
  `LRR_ASSERT_IMP(a_single_redraw, cmd.set_redraw, !sts.redraw_done,
    "more than one redraw")

endmodule

`default_nettype wire

// ===== rtl/core/lrr_ctrl.sv =====
`default_nettype none

module lrr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  input  wire lrr_pkg::lrr_sts_t sts,
  output lrr_pkg::lrr_cmd_t    cmd
);
  import lrr_pkg::*;

  lrr_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_ADV;
      end
      ST_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = sts.bounds_eq ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.repeat_hit) begin
          cmd.set_redraw = 1'b1;
          state_nxt      = ST_MUL_LO;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.take  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_tready) || cmd.take;
  assign out_tvalid    = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/lrr_dp.sv =====
`default_nettype none

module lrr_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [63:0]         cfg_wr_data,
  input  wire logic signed [31:0]  low_bound,
  input  wire logic signed [31:0]  high_bound,
  input  wire logic                allow_repeat,
  input  wire logic                reseed,
  input  wire logic [63:0]         new_seed,
  input  wire lrr_pkg::lrr_cmd_t   cmd,
  output lrr_pkg::lrr_sts_t        sts,
  output logic signed [31:0]       value,
  output logic                     redrawn
);
  import lrr_pkg::*;

  logic [SEED_W-1:0]   seed_r;
  logic [VAL_W-1:0]    last_r;
  logic [VAL_W-1:0]    lo_r, hi_r, width_r;
  logic                allow_r, redraw_r;
  logic [PROD_W-1:0]   prod_lo_r;
  logic [VAL_W-1:0]    prod_hi_r;
  logic [DIV_BITS-1:0] dvd_r;
  logic [VAL_W-1:0]    rem_r;
  logic [VAL_W-1:0]    value_r;
  logic                redrawn_r;

  logic                swap;
  logic [VAL_W-1:0]    lo_nxt, hi_nxt;
  logic [VAL_W-1:0]    mul_a;
  logic [PROD_W-1:0]   prod;
  logic [SEED_W-1:0]   seed_nxt;
  logic [VAL_W:0]      rem_sh;
  logic [VAL_W+1:0]    diff;
  logic [VAL_W-1:0]    draw_v, result;

  assign swap   = low_bound > high_bound;
  assign lo_nxt = swap ? high_bound : low_bound;
  assign hi_nxt = swap ? low_bound : high_bound;

  // one 32x30 multiplier shared by both seed halves
  assign mul_a = cmd.mul_hi ? seed_r[SEED_W-1:VAL_W] : seed_r[VAL_W-1:0];
  assign prod  = {{MUL_W{1'b0}}, mul_a} * {{VAL_W{1'b0}}, LCG_MUL};

  assign seed_nxt = {prod_hi_r, {VAL_W{1'b0}}} + {{(SEED_W-PROD_W){1'b0}}, prod_lo_r}
                  + LCG_INC;

  // restoring division step, remainder stays below width
  assign rem_sh = {rem_r, dvd_r[DIV_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, width_r};

  assign draw_v = rem_r + lo_r;
  assign result = (lo_r == hi_r) ? lo_r : draw_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= SEED_RESET;
      last_r   <= '0;
      redraw_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end else if (cmd.load && reseed) begin
        seed_r <= new_seed;
      end else if (cmd.adv) begin
        seed_r <= seed_nxt;
      end
      if (cmd.take) begin
        last_r <= result;
      end
      if (cmd.load) begin
        redraw_r <= 1'b0;
      end else if (cmd.set_redraw) begin
        redraw_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      width_r <= hi_nxt - lo_nxt;
      allow_r <= allow_repeat;
    end
    if (cmd.mul_lo) begin
      prod_lo_r <= prod;
    end
    if (cmd.mul_hi) begin
      prod_hi_r <= prod[VAL_W-1:0];
    end
    if (cmd.adv) begin
      dvd_r <= seed_nxt[SEED_W-1:SHIFT];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DIV_BITS-2:0], 1'b0};
      rem_r <= diff[VAL_W+1] ? rem_sh[VAL_W-1:0] : diff[VAL_W-1:0];
    end
    if (cmd.take) begin
      value_r   <= result;
      redrawn_r <= redraw_r;
    end
  end

  assign sts.bounds_eq   = (lo_r == hi_r);
  assign sts.repeat_hit  = (draw_v == last_r) && !allow_r && !redraw_r;
  assign sts.redraw_done = redraw_r;

  assign value   = value_r;
  assign redrawn = redrawn_r;

endmodule

`default_nettype wire
